@@ design/aps_pkg.sv @@
// ----------------------------------------------------------------------------
// aps_pkg: shared types and constants
// Register map, reset values and field widths of the slant-path stepper.
// ----------------------------------------------------------------------------
package aps_pkg;

    localparam int AddrW = 5;
    localparam int DataW = 32;
    localparam int SineW = 31;

    localparam logic [2:0] REG_EARTH_RADIUS = 3'd0;
    localparam logic [2:0] REG_TOP_ALT      = 3'd1;
    localparam logic [2:0] REG_CUTOFF_ALT   = 3'd2;
    localparam logic [2:0] REG_STEP_LENGTH  = 3'd3;
    localparam logic [2:0] REG_VIEW_SINE    = 3'd4;

    localparam logic [31:0]      RST_EARTH_RADIUS = 32'd417529856;
    localparam logic [31:0]      RST_TOP_ALT      = 32'd4259840;
    localparam logic [31:0]      RST_CUTOFF_ALT   = 32'd4259840;
    localparam logic [31:0]      RST_STEP_LENGTH  = 32'd65536;
    localparam logic [SineW-1:0] RST_VIEW_SINE    = '0;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    typedef struct packed {
        logic [31:0]      earth_radius;
        logic [31:0]      top_altitude;
        logic [31:0]      cutoff_altitude;
        logic [31:0]      step_length;
        logic [SineW-1:0] view_sine;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic done;
    } unit_ctl_t;

endpackage

@@ design/aps_regs.sv @@
// ----------------------------------------------------------------------------
// aps_regs: configuration registers
// Register file behind the APB-style port.
// ----------------------------------------------------------------------------
module aps_regs (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [aps_pkg::AddrW-1:0] paddr,
    input  logic [aps_pkg::DataW-1:0] pwdata,
    output logic [aps_pkg::DataW-1:0] prdata,
    output aps_pkg::cfg_t            cfg
);

    aps_pkg::cfg_t cfg_reg;
    logic [2:0]    idx;
    logic          wr_en;

    assign idx   = paddr[4:2];
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.earth_radius    <= aps_pkg::RST_EARTH_RADIUS;
            cfg_reg.top_altitude    <= aps_pkg::RST_TOP_ALT;
            cfg_reg.cutoff_altitude <= aps_pkg::RST_CUTOFF_ALT;
            cfg_reg.step_length     <= aps_pkg::RST_STEP_LENGTH;
            cfg_reg.view_sine       <= aps_pkg::RST_VIEW_SINE;
        end else if (wr_en) begin
            case (idx)
                aps_pkg::REG_EARTH_RADIUS: cfg_reg.earth_radius    <= pwdata;
                aps_pkg::REG_TOP_ALT:      cfg_reg.top_altitude    <= pwdata;
                aps_pkg::REG_CUTOFF_ALT:   cfg_reg.cutoff_altitude <= pwdata;
                aps_pkg::REG_STEP_LENGTH:  cfg_reg.step_length     <= pwdata;
                aps_pkg::REG_VIEW_SINE:    cfg_reg.view_sine       <= pwdata[aps_pkg::SineW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            aps_pkg::REG_EARTH_RADIUS: prdata = cfg_reg.earth_radius;
            aps_pkg::REG_TOP_ALT:      prdata = cfg_reg.top_altitude;
            aps_pkg::REG_CUTOFF_ALT:   prdata = cfg_reg.cutoff_altitude;
            aps_pkg::REG_STEP_LENGTH:  prdata = cfg_reg.step_length;
            aps_pkg::REG_VIEW_SINE:    prdata = {1'b0, cfg_reg.view_sine};
            default:                   prdata = '0;
        endcase
    end

endmodule

@@ design/aps_div.sv @@
// ----------------------------------------------------------------------------
// aps_div: restoring divider
// Produces a 31-bit quotient of a 64-bit numerator, one bit per cycle.
// ----------------------------------------------------------------------------
module aps_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [32:0] den,
    output logic        done,
    output logic [30:0] quot
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [32:0] rem_reg;
    logic [30:0] low_reg;
    logic [30:0] quot_reg;
    logic [33:0] rem_shift;
    logic        fits;

    assign rem_shift = {rem_reg, low_reg[30]};
    assign fits      = rem_shift >= {1'b0, den};
    assign done      = done_reg;
    assign quot      = quot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd30;
                rem_reg  <= num[63:31];
                low_reg  <= num[30:0];
                quot_reg <= '0;
            end else if (busy_reg) begin
                rem_reg  <= fits ? 33'(rem_shift - {1'b0, den}) : rem_shift[32:0];
                low_reg  <= {low_reg[29:0], 1'b0};
                quot_reg <= {quot_reg[29:0], fits};
                if (cnt_reg == 5'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
        end
    end

endmodule

@@ design/aps_sqrt.sv @@
// ----------------------------------------------------------------------------
// aps_sqrt: digit-by-digit square root
// Floor square root of a 72-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module aps_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [71:0] radicand,
    output logic        done,
    output logic [35:0] root
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [71:0] rad_reg;
    logic [37:0] rem_reg;
    logic [35:0] root_reg;
    logic [38:0] rem_shift;
    logic [38:0] trial;
    logic        fits;

    assign rem_shift = {rem_reg[36:0], rad_reg[71:70]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign fits      = rem_shift >= trial;
    assign done      = done_reg;
    assign root      = root_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd35;
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (busy_reg) begin
                rad_reg  <= {rad_reg[69:0], 2'b00};
                rem_reg  <= fits ? 38'(rem_shift - trial) : rem_shift[37:0];
                root_reg <= {root_reg[34:0], fits};
                if (cnt_reg == 6'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
        end
    end

endmodule

@@ design/atmospheric_path_step.sv @@
// ----------------------------------------------------------------------------
// atmospheric_path_step: slant-path altitude stepper
// Sequencer with one shared multiplier, a serial divider and a serial root.
// ----------------------------------------------------------------------------
// A request is accepted only while the block is idle. Its result is loaded
// into the output register after the serial divider, each of the two serial
// square roots, seven passes through one shared 33x33 multiplier and the
// sequencing states, all run one after another by the sequencer. When the
// angle needs no division (clamped or zero radius) the divider is skipped.
// A request whose altitude lies above the cutoff goes from the check state
// straight to the final state. The next request can be accepted in the cycle
// after a result is loaded. A finished result waits in the output register
// while the next request is already being worked on; if it is still waiting
// when the next result is ready, the sequencer holds until it is taken.
module atmospheric_path_step (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [aps_pkg::AddrW-1:0] paddr,
    input  logic [aps_pkg::DataW-1:0] pwdata,
    output logic [aps_pkg::DataW-1:0] prdata,
    output logic                      pready,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [31:0]               s_tdata,  // start_altitude
    input  logic [0:0]                s_tuser,  // mode
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [63:0]               m_tdata,  // mid_altitude, step_rise
    output logic [1:0]                m_tuser   // done_res, angle_clamped
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CHK  = 4'd1;
    localparam logic [3:0] ST_MNUM = 4'd2;
    localparam logic [3:0] ST_DIVI = 4'd3;
    localparam logic [3:0] ST_DIV  = 4'd4;
    localparam logic [3:0] ST_MXX  = 4'd5;
    localparam logic [3:0] ST_SQ1I = 4'd6;
    localparam logic [3:0] ST_SQ1  = 4'd7;
    localparam logic [3:0] ST_MP   = 4'd8;
    localparam logic [3:0] ST_MQL  = 4'd9;
    localparam logic [3:0] ST_MQH  = 4'd10;
    localparam logic [3:0] ST_AQH  = 4'd11;
    localparam logic [3:0] ST_ARR  = 4'd12;
    localparam logic [3:0] ST_ALL  = 4'd13;
    localparam logic [3:0] ST_SQ2  = 4'd14;
    localparam logic [3:0] ST_FIN  = 4'd15;

    aps_pkg::cfg_t     cfg;
    aps_pkg::unit_ctl_t div_ctl;
    aps_pkg::unit_ctl_t sq_ctl;

    logic [3:0]  state_reg, state_next;
    logic [31:0] cur_reg;
    logic [31:0] z_reg;
    logic        done_reg;
    logic        clamp_reg;
    logic [32:0] rad_reg;
    logic [32:0] radmax_reg;
    logic [30:0] x_reg;
    logic [30:0] c_reg;
    logic [64:0] p_reg;
    logic [65:0] prod_reg;
    logic [97:0] acc_reg;
    logic        ovalid_reg;
    logic [63:0] odata_reg;
    logic [1:0]  ouser_reg;

    logic [32:0] mul_a;
    logic [32:0] mul_b;
    logic [63:0] thr;
    logic        clamp_now;
    logic [71:0] sq_in;
    logic [30:0] quot;
    logic [35:0] root;
    logic [35:0] rise_full;
    logic [31:0] rise;
    logic [32:0] mid_sum;
    logic [32:0] nz_sum;
    logic        out_free;

    aps_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    aps_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_ctl.start),
        .num     (prod_reg[63:0]),
        .den     (rad_reg),
        .done    (div_ctl.done),
        .quot    (quot)
    );

    aps_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_ctl.start),
        .radicand (sq_in),
        .done     (sq_ctl.done),
        .root     (root)
    );

    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = ouser_reg;
    assign out_free = !ovalid_reg || m_tready;

    assign thr       = {1'b0, rad_reg, 30'd0} + {31'd0, rad_reg};
    assign clamp_now = (rad_reg == '0) ? (prod_reg[63:0] != '0) : (prod_reg[63:0] >= thr);

    assign div_ctl.start = (state_reg == ST_DIVI) && !clamp_now && (rad_reg != '0);
    assign sq_ctl.start  = (state_reg == ST_SQ1I) || (state_reg == ST_ALL);
    assign sq_in = (state_reg == ST_SQ1I)
                 ? {11'd0, 61'(61'h1000_0000_0000_0000 - prod_reg[60:0])}
                 : 72'(acc_reg[71:0] + {6'd0, prod_reg});

    assign rise_full = (root >= {3'd0, rad_reg}) ? 36'(root - {3'd0, rad_reg}) : '0;
    assign rise      = (rise_full[35:32] != '0) ? 32'hFFFF_FFFF : rise_full[31:0];
    assign mid_sum   = {1'b0, z_reg} + {2'b0, rise[31:1]};
    assign nz_sum    = {1'b0, z_reg} + {1'b0, rise};

    always_comb begin
        case (state_reg)
            ST_MNUM: begin
                mul_a = {2'b0, cfg.view_sine};
                mul_b = radmax_reg;
            end
            ST_MXX: begin
                mul_a = {2'b0, x_reg};
                mul_b = {2'b0, x_reg};
            end
            ST_MP: begin
                mul_a = rad_reg;
                mul_b = {1'b0, cfg.step_length};
            end
            ST_MQL: begin
                mul_a = prod_reg[32:0];
                mul_b = {2'b0, c_reg};
            end
            ST_MQH: begin
                mul_a = {1'b0, p_reg[64:33]};
                mul_b = {2'b0, c_reg};
            end
            ST_AQH: begin
                mul_a = rad_reg;
                mul_b = rad_reg;
            end
            ST_ARR: begin
                mul_a = {1'b0, cfg.step_length};
                mul_b = {1'b0, cfg.step_length};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_CHK;
            ST_CHK:  state_next = (z_reg > cfg.cutoff_altitude) ? ST_FIN : ST_MNUM;
            ST_MNUM: state_next = ST_DIVI;
            ST_DIVI: state_next = div_ctl.start ? ST_DIV : ST_MXX;
            ST_DIV:  if (div_ctl.done) state_next = ST_MXX;
            ST_MXX:  state_next = ST_SQ1I;
            ST_SQ1I: state_next = ST_SQ1;
            ST_SQ1:  if (sq_ctl.done) state_next = ST_MP;
            ST_MP:   state_next = ST_MQL;
            ST_MQL:  state_next = ST_MQH;
            ST_MQH:  state_next = ST_AQH;
            ST_AQH:  state_next = ST_ARR;
            ST_ARR:  state_next = ST_ALL;
            ST_ALL:  state_next = ST_SQ2;
            ST_SQ2:  if (sq_ctl.done) state_next = ST_FIN;
            ST_FIN:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cur_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_FIN && out_free) begin
                ovalid_reg <= 1'b1;
                if (done_reg) begin
                    cur_reg <= z_reg;
                end else begin
                    cur_reg <= nz_sum[32] ? 32'hFFFF_FFFF : nz_sum[31:0];
                end
            end else if (ovalid_reg && m_tready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE: begin
                z_reg <= s_tuser[0] ? cur_reg : s_tdata;
            end
            ST_CHK: begin
                done_reg   <= z_reg > cfg.cutoff_altitude;
                clamp_reg  <= 1'b0;
                rad_reg    <= {1'b0, z_reg} + {1'b0, cfg.earth_radius};
                radmax_reg <= {1'b0, cfg.earth_radius} + {1'b0, cfg.top_altitude};
            end
            ST_DIVI: begin
                clamp_reg <= clamp_now;
                x_reg     <= clamp_now ? aps_pkg::ONE_Q30 : '0;
            end
            ST_DIV: begin
                if (div_ctl.done) x_reg <= quot;
            end
            ST_SQ1: begin
                if (sq_ctl.done) c_reg <= root[30:0];
            end
            ST_MQL: begin
                p_reg <= prod_reg[64:0];
            end
            ST_MQH: begin
                acc_reg <= {32'd0, prod_reg};
            end
            ST_AQH: begin
                acc_reg <= 98'(acc_reg + {prod_reg[64:0], 33'd0});
            end
            ST_ARR: begin
                acc_reg <= 98'((acc_reg >> 29) + {32'd0, prod_reg});
            end
            ST_FIN: begin
                if (out_free) begin
                    if (done_reg) begin
                        odata_reg <= '0;
                        ouser_reg <= 2'b01;
                    end else begin
                        odata_reg <= {rise, mid_sum[32] ? 32'hFFFF_FFFF : mid_sum[31:0]};
                        ouser_reg <= {clamp_reg, 1'b0};
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

@@ design/aps_check.sv @@
// ----------------------------------------------------------------------------
// aps_check: port-level checks
// Assertions on the stepper's ports, bound to the top level.
// ----------------------------------------------------------------------------
module aps_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        pready,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A result that is not taken stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // The block works on one request at a time.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // A done result carries no step.
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata == 64'd0) && !m_tuser[1])
        else $error("done result with step data");

    // Reset empties the output register.
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid && pready)
        else $error("output valid after reset");

endmodule

bind atmospheric_path_step aps_check u_aps_check (.*);

@@ tb/sv/tb_atmospheric_path_step.sv @@
// ----------------------------------------------------------------------------
// tb_atmospheric_path_step: self-checking bench for the slant-path stepper
// Drives restart and continue requests over several register settings,
// predicts every result with an exact integer model of the step, and
// compares each result with the oldest prediction; both stream sides stall
// at random except in the last random phase, which runs without stalls.
// ----------------------------------------------------------------------------
module tb_atmospheric_path_step;

    localparam int IdleLimit = 20000;

    typedef struct {
        bit [31:0] mid_altitude;
        bit [31:0] step_rise;
        bit        done_res;
        bit        angle_clamped;
    } step_result_t;

    class altitude_board;
        bit [31:0] earth_radius, top_altitude, cutoff_altitude, step_length;
        bit [30:0] view_sine;
        bit [31:0] altitude;
        step_result_t pending_steps[$];
        int errors, requests, steps, dones, clamps;

        function new();
            earth_radius = aps_pkg::RST_EARTH_RADIUS;
            top_altitude = aps_pkg::RST_TOP_ALT;
            cutoff_altitude = aps_pkg::RST_CUTOFF_ALT;
            step_length = aps_pkg::RST_STEP_LENGTH;
            view_sine = aps_pkg::RST_VIEW_SINE;
            altitude = 0;
        endfunction

        function automatic bit [35:0] floor_root(bit [127:0] v);
            bit [35:0] r;
            bit [127:0] t;
            r = 0;
            for (int b = 35; b >= 0; b--) begin
                t = r | (36'd1 << b);
                if (t * t <= v) begin
                    r = t[35:0];
                end
            end
            return r;
        endfunction

        function void set_reg(logic [2:0] idx, bit [31:0] value);
            case (idx)
                aps_pkg::REG_EARTH_RADIUS: earth_radius = value;
                aps_pkg::REG_TOP_ALT:      top_altitude = value;
                aps_pkg::REG_CUTOFF_ALT:   cutoff_altitude = value;
                aps_pkg::REG_STEP_LENGTH:  step_length = value;
                aps_pkg::REG_VIEW_SINE:    view_sine = value[30:0];
                default: ;
            endcase
        endfunction

        function void note_request(bit mode, bit [31:0] start);
            bit [31:0] z;
            bit [127:0] rad, radmax, num, x, c, s, root, rise, mid, nz, len;
            step_result_t e;
            requests++;
            z = mode ? altitude : start;
            e = '{0, 0, 0, 0};
            if (z > cutoff_altitude) begin
                altitude = z;
                e.done_res = 1;
                dones++;
            end else begin
                len = step_length;
                rad = 128'(z) + earth_radius;
                radmax = 128'(earth_radius) + top_altitude;
                num = 128'(view_sine) * radmax;
                if (rad == 0) begin
                    x = (num == 0) ? 0 : (128'd1 << 30) + 1;
                end else begin
                    x = num / rad;
                end
                if (x > (128'd1 << 30)) begin
                    x = 128'd1 << 30;
                    e.angle_clamped = 1;
                    clamps++;
                end
                c = floor_root((128'd1 << 60) - x * x);
                s = rad * rad + len * len + ((rad * len * c) >> 29);
                root = floor_root(s);
                rise = (root >= rad) ? root - rad : 0;
                if (rise > 32'hFFFF_FFFF) begin
                    rise = 32'hFFFF_FFFF;
                end
                mid = 128'(z) + (rise >> 1);
                if (mid > 32'hFFFF_FFFF) begin
                    mid = 32'hFFFF_FFFF;
                end
                nz = 128'(z) + rise;
                if (nz > 32'hFFFF_FFFF) begin
                    nz = 32'hFFFF_FFFF;
                end
                altitude = nz[31:0];
                e.mid_altitude = mid[31:0];
                e.step_rise = rise[31:0];
                steps++;
            end
            pending_steps.insert(pending_steps.size(), e);
        endfunction

        function void check_result(bit [63:0] data, bit [1:0] user);
            step_result_t e;
            if (pending_steps.size() == 0) begin
                $error("result 0x%h/%b arrived with nothing expected", data, user);
                errors++;
                return;
            end
            e = pending_steps.pop_front();
            if (data[31:0] !== e.mid_altitude) begin
                $error("mid_altitude expected 0x%h got 0x%h", e.mid_altitude, data[31:0]);
                errors++;
            end
            if (data[63:32] !== e.step_rise) begin
                $error("step_rise expected 0x%h got 0x%h", e.step_rise, data[63:32]);
                errors++;
            end
            if (user[0] !== e.done_res) begin
                $error("done_res expected %0d got %0d", e.done_res, user[0]);
                errors++;
            end
            if (user[1] !== e.angle_clamped) begin
                $error("angle_clamped expected %0d got %0d", e.angle_clamped, user[1]);
                errors++;
            end
        endfunction
    endclass

    logic                      aclk = 0;
    logic                      aresetn = 0;
    logic                      psel = 0, penable = 0, pwrite = 0;
    logic [aps_pkg::AddrW-1:0] paddr = '0;
    logic [aps_pkg::DataW-1:0] pwdata = '0;
    logic [aps_pkg::DataW-1:0] prdata;
    logic                      pready;
    logic                      s_tvalid = 0;
    logic                      s_tready;
    logic [31:0]               s_tdata = '0;
    logic [0:0]                s_tuser = '0;
    logic                      m_tvalid;
    logic                      m_tready = 0;
    logic [63:0]               m_tdata;
    logic [1:0]                m_tuser;

    altitude_board board = new();
    int sent = 0;
    int sender_idle = 30;
    int receiver_idle = 73;
    int idle_cycles = 0;

    atmospheric_path_step dut (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                board.note_request(s_tuser[0], s_tdata);
            end
            if (m_tvalid && m_tready) begin
                board.check_result(m_tdata, m_tuser);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IdleLimit) begin
                $display("tb_atmospheric_path_step: errors");
                $finish;
            end
            m_tready <= ($urandom_range(0, 99) >= receiver_idle);
        end
    end

    task automatic write_reg(logic [2:0] idx, bit [31:0] value);
        @(posedge aclk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1;
        do @(posedge aclk); while (!pready);
        board.set_reg(idx, value);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic send_request(bit mode, bit [31:0] start);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < sender_idle) begin
            gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= mode;
        s_tdata <= start;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic drain();
        @(posedge aclk);
        s_tvalid <= 0;
        while (board.pending_steps.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic set_all(bit [31:0] er, bit [31:0] top, bit [31:0] cut,
                           bit [31:0] len, bit [31:0] vs);
        write_reg(aps_pkg::REG_EARTH_RADIUS, er);
        write_reg(aps_pkg::REG_TOP_ALT, top);
        write_reg(aps_pkg::REG_CUTOFF_ALT, cut);
        write_reg(aps_pkg::REG_STEP_LENGTH, len);
        write_reg(aps_pkg::REG_VIEW_SINE, vs);
    endtask

    initial begin
        bit [31:0] er, top, cut, len, vs;
        int n;
        repeat (10) @(posedge aclk);
        aresetn <= 1;

        // Directed part: defaults, restart above the cutoff, a rising path, extreme and zero-radius settings.
        send_request(0, 0);
        send_request(1, 32'hFFFF_FFFF);
        send_request(0, 32'hFFFF_FFFF);
        send_request(1, 0);
        send_request(0, aps_pkg::RST_CUTOFF_ALT);
        send_request(1, 0);
        drain();
        send_request(0, aps_pkg::RST_CUTOFF_ALT + 1);
        drain();
        set_all(aps_pkg::RST_EARTH_RADIUS, aps_pkg::RST_TOP_ALT, aps_pkg::RST_CUTOFF_ALT,
                32'd20 << 16, aps_pkg::ONE_Q30);
        send_request(0, 32'd10 << 16);
        repeat (4) send_request(1, 0);
        drain();
        set_all(0, 32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_request(0, 0);
        send_request(1, 0);
        send_request(0, 32'hFFFF_FFF0);
        send_request(1, 0);
        drain();
        set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'h2000_0000);
        send_request(0, 32'h8000_0000);
        send_request(1, 0);
        send_request(1, 0);
        drain();
        write_reg(aps_pkg::REG_VIEW_SINE, 0);
        write_reg(aps_pkg::REG_EARTH_RADIUS, 0);
        send_request(0, 0);
        send_request(1, 0);
        drain();

        // Random phases of restart-then-continue paths, with some noise.
        while (sent < 735) begin
            if (sent >= 500) begin
                sender_idle = 0;
                receiver_idle = 0;
            end else if (sent >= 250) begin
                sender_idle = 73;
                receiver_idle = 30;
            end
            er = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1)) ? 0 : 32'hFFFF_FFFF)
                 : $urandom_range(0, 32'd8000 << 16);
            top = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32'd200 << 16);
            cut = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1)) ? 0 : 32'hFFFF_FFFF)
                  : $urandom_range(0, 32'd150 << 16);
            len = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1)) ? 0 : $urandom)
                  : $urandom_range(0, 32'd25 << 16);
            vs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32'h7FFF_FFFF)
                 : $urandom_range(0, aps_pkg::ONE_Q30);
            set_all(er, top, cut, len, vs);
            n = $urandom_range(15, 40);
            repeat (n) begin
                if ($urandom_range(0, 99) < 80) begin
                    if ($urandom_range(0, 5) == 0) begin
                        send_request(0, $urandom_range(0, cut));
                    end else begin
                        send_request(1, $urandom);
                    end
                end else begin
                    send_request($urandom_range(0, 1), $urandom);
                end
            end
            drain();
        end
        drain();
        repeat (150) @(posedge aclk);

        $display("Covered %0d requests: %0d steps, %0d done, %0d clamped angles.",
                 board.requests, board.steps, board.dones, board.clamps);
        if (board.errors == 0 && board.pending_steps.size() == 0) begin
            $display("tb_atmospheric_path_step: clean");
        end else begin
            $display("tb_atmospheric_path_step: errors");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
design/aps_pkg.sv
design/aps_regs.sv
design/aps_div.sv
design/aps_sqrt.sv
design/atmospheric_path_step.sv
design/aps_check.sv
tb/sv/tb_atmospheric_path_step.sv
